// ----- hdl/bfpa_pkg.sv -----
// Shared constants, codes and types for the best-fit page allocator.
// No dependencies; used by bfpa_ctrl, bfpa_dp and best_fit_page_allocator.
package bfpa_pkg;

  localparam int MAP_PAGES   = 1024;
  localparam int COUNT_WIDTH = 8;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 10;
  localparam int NCOUNT_W = 11;
  localparam int FFP_W    = 11;
  localparam int STATUS_W = 3;
  localparam int OUTCNT_W = 8;

  localparam logic [OPCODE_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INCREF = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DECREF = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_GETREF = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PARTIAL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADCNT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd6;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD,
    CMD_EVAL,
    CMD_WR,
    CMD_CLEAR,
    CMD_EMIT
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_err;
    logic is_init;
    logic sweep_done;
    logic do_write;
  } stat_t;

endpackage

// ----- hdl/bfpa_dp.sv -----
// Datapath of the page allocator: page memory, address sweep, run tracking, results.
// Depends on bfpa_pkg.
module bfpa_dp #(
  parameter int MAP_PAGES   = bfpa_pkg::MAP_PAGES,
  parameter int COUNT_WIDTH = bfpa_pkg::COUNT_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bfpa_pkg::cmd_e                 cmd_i,
  output bfpa_pkg::stat_t                stat_o,
  input  logic                           cfg_valid_i,
  input  logic [bfpa_pkg::FFP_W-1:0]     first_free_page_i,
  input  logic [bfpa_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [bfpa_pkg::INDEX_W-1:0]   page_index_i,
  input  logic [bfpa_pkg::NCOUNT_W-1:0]  page_count_i,
  output logic [bfpa_pkg::STATUS_W-1:0]  status_o,
  output logic [bfpa_pkg::INDEX_W-1:0]   base_page_o,
  output logic [bfpa_pkg::OUTCNT_W-1:0]  count_value_o,
  output logic                           pages_freed_o
);

  localparam int AW = $clog2(MAP_PAGES);
  localparam int LW = (AW + 2 > 12) ? AW + 2 : 12;
  localparam int WW = COUNT_WIDTH + 1;
  localparam logic [LW-1:0] NP = LW'(MAP_PAGES);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);

  // Memory word: free bit on top, reference count below.
  logic [WW-1:0] mem [MAP_PAGES];

  logic [bfpa_pkg::OPCODE_W-1:0] op_q;
  logic [LW-1:0] n_q, cnt_q, end_q;
  logic [bfpa_pkg::FFP_W-1:0] ffp_q;
  logic rd_vld_q;
  logic [LW-1:0] rd_addr_q;
  logic [WW-1:0] rd_q, wr_word_q;
  logic [LW-1:0] run_start_q, run_len_q, best_start_q, best_len_q;
  logic found_q, zero_q, still_q;
  logic [bfpa_pkg::STATUS_W-1:0] res_status_q;
  logic [LW-1:0] res_base_q;
  logic [COUNT_WIDTH-1:0] res_cnt_q;
  logic res_freed_q;

  logic [LW-1:0] n_in, idx_in, ffp_l;
  logic pre_err, is_init;
  logic [bfpa_pkg::STATUS_W-1:0] pre_status;
  logic [LW-1:0] pre_start, pre_end, pre_n;

  assign n_in   = LW'(page_count_i);
  assign idx_in = LW'(page_index_i);
  assign ffp_l  = LW'(ffp_q);

  always_comb begin
    pre_err    = 1'b0;
    is_init    = 1'b0;
    pre_status = bfpa_pkg::ST_OK;
    pre_start  = idx_in;
    pre_end    = idx_in + n_in;
    pre_n      = n_in;
    case (opcode_i)
      bfpa_pkg::OP_INIT: begin
        is_init   = 1'b1;
        pre_start = '0;
        pre_end   = NP;
      end
      bfpa_pkg::OP_ALLOC: begin
        pre_start = '0;
        pre_end   = NP;
        if (n_in == '0) begin
          pre_err    = 1'b1;
          pre_status = bfpa_pkg::ST_BADCNT;
        end
      end
      bfpa_pkg::OP_FREE: begin
        if (n_in == '0) begin
          pre_err    = 1'b1;
          pre_status = bfpa_pkg::ST_BADCNT;
        end else if (idx_in < ffp_l || idx_in + n_in > NP) begin
          pre_err    = 1'b1;
          pre_status = bfpa_pkg::ST_RANGE;
        end
      end
      bfpa_pkg::OP_INCREF, bfpa_pkg::OP_DECREF, bfpa_pkg::OP_GETREF: begin
        pre_n   = LW'(1);
        pre_end = idx_in + LW'(1);
        if (idx_in >= NP) begin
          pre_err    = 1'b1;
          pre_status = bfpa_pkg::ST_RANGE;
        end
      end
      default: begin
        pre_err    = 1'b1;
        pre_status = bfpa_pkg::ST_RANGE;
      end
    endcase
  end

  // Closing a run at a busy page or at the end of the map.
  logic run_fits;
  assign run_fits = (run_len_q >= n_q) && (!found_q || run_len_q < best_len_q);

  // Final decision once the sweep has finished.
  logic [COUNT_WIDTH-1:0] cur_c;
  logic cur_free, fin_found, ev_write, ev_freed;
  logic [LW-1:0] fin_start, ev_start, ev_base;
  logic [bfpa_pkg::STATUS_W-1:0] ev_status;
  logic [COUNT_WIDTH-1:0] ev_cnt;
  logic [WW-1:0] ev_word;

  assign cur_c     = rd_q[COUNT_WIDTH-1:0];
  assign cur_free  = rd_q[WW-1];
  assign fin_found = found_q || run_fits;
  assign fin_start = run_fits ? run_start_q : best_start_q;

  always_comb begin
    ev_status = bfpa_pkg::ST_OK;
    ev_base   = '0;
    ev_cnt    = '0;
    ev_freed  = 1'b0;
    ev_write  = 1'b0;
    ev_word   = '0;
    ev_start  = cnt_q;
    case (op_q)
      bfpa_pkg::OP_ALLOC: begin
        if (!fin_found) begin
          ev_status = bfpa_pkg::ST_NOFIT;
        end else begin
          ev_base  = fin_start;
          ev_start = fin_start;
          ev_write = 1'b1;
          ev_word  = {1'b0, CONE};
        end
      end
      bfpa_pkg::OP_FREE: begin
        ev_start = end_q - n_q;
        if (zero_q) begin
          ev_status = bfpa_pkg::ST_ZERO;
        end else if (n_q > LW'(1) && still_q) begin
          ev_status = bfpa_pkg::ST_PARTIAL;
        end else begin
          ev_write = 1'b1;
          ev_freed = !still_q;
          ev_word  = still_q ? {cur_free, cur_c - CONE} : {1'b1, {COUNT_WIDTH{1'b0}}};
        end
      end
      bfpa_pkg::OP_INCREF: begin
        ev_start = end_q - LW'(1);
        if (cur_c == CMAX) begin
          ev_status = bfpa_pkg::ST_SAT;
          ev_cnt    = cur_c;
        end else begin
          ev_cnt   = cur_c + CONE;
          ev_write = 1'b1;
          ev_word  = {cur_free, cur_c + CONE};
        end
      end
      bfpa_pkg::OP_DECREF: begin
        ev_start = end_q - LW'(1);
        if (cur_c == '0) begin
          ev_status = bfpa_pkg::ST_ZERO;
        end else begin
          ev_cnt   = cur_c - CONE;
          ev_write = 1'b1;
          ev_word  = {cur_free, cur_c - CONE};
        end
      end
      default: begin
        ev_cnt = cur_c;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= bfpa_pkg::OP_INIT;
      n_q      <= '0;
      cnt_q    <= '0;
      end_q    <= NP;
      ffp_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ffp_q <= first_free_page_i;
      end
      rd_vld_q <= (cmd_i == bfpa_pkg::CMD_RD);
      case (cmd_i)
        bfpa_pkg::CMD_LOAD: begin
          op_q  <= opcode_i;
          n_q   <= pre_n;
          cnt_q <= pre_start;
          end_q <= pre_end;
        end
        bfpa_pkg::CMD_EVAL: begin
          cnt_q <= ev_start;
          end_q <= ev_start + n_q;
        end
        bfpa_pkg::CMD_RD, bfpa_pkg::CMD_WR, bfpa_pkg::CMD_CLEAR: begin
          cnt_q <= cnt_q + LW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Sweep bookkeeping and results.
  always_ff @(posedge clk_i) begin
    rd_addr_q <= cnt_q;
    if (cmd_i == bfpa_pkg::CMD_LOAD) begin
      run_len_q    <= '0;
      run_start_q  <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      found_q      <= 1'b0;
      zero_q       <= 1'b0;
      still_q      <= 1'b0;
      res_status_q <= pre_status;
      res_base_q   <= '0;
      res_cnt_q    <= '0;
      res_freed_q  <= 1'b0;
    end else if (cmd_i == bfpa_pkg::CMD_EVAL) begin
      res_status_q <= ev_status;
      res_base_q   <= ev_base;
      res_cnt_q    <= ev_cnt;
      res_freed_q  <= ev_freed;
      wr_word_q    <= ev_word;
    end else if (rd_vld_q) begin
      if (op_q == bfpa_pkg::OP_ALLOC) begin
        if (cur_free) begin
          if (run_len_q == '0) begin
            run_start_q <= rd_addr_q;
          end
          run_len_q <= run_len_q + LW'(1);
        end else begin
          if (run_fits) begin
            found_q      <= 1'b1;
            best_start_q <= run_start_q;
            best_len_q   <= run_len_q;
          end
          run_len_q <= '0;
        end
      end else begin
        if (cur_c == '0) zero_q <= 1'b1;
        if (cur_c > CONE) still_q <= 1'b1;
      end
    end
    if (cmd_i == bfpa_pkg::CMD_EMIT) begin
      status_o      <= res_status_q;
      base_page_o   <= bfpa_pkg::INDEX_W'(res_base_q);
      count_value_o <= bfpa_pkg::OUTCNT_W'(res_cnt_q);
      pages_freed_o <= res_freed_q;
    end
  end

  // Page memory: one write and one registered read per cycle.
  logic we;
  logic [WW-1:0] wdata;
  assign we = (cmd_i == bfpa_pkg::CMD_WR) || (cmd_i == bfpa_pkg::CMD_CLEAR);

  always_comb begin
    if (cmd_i == bfpa_pkg::CMD_CLEAR) begin
      wdata = '0;
    end else if (op_q == bfpa_pkg::OP_INIT) begin
      wdata = {(cnt_q >= ffp_l), {COUNT_WIDTH{1'b0}}};
    end else begin
      wdata = wr_word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cnt_q[AW-1:0]] <= wdata;
    end
    if (cmd_i == bfpa_pkg::CMD_RD) begin
      rd_q <= mem[cnt_q[AW-1:0]];
    end
  end

  assign stat_o.pre_err    = pre_err;
  assign stat_o.is_init    = is_init;
  assign stat_o.sweep_done = (cnt_q == end_q);
  assign stat_o.do_write   = ev_write;

endmodule

// ----- hdl/bfpa_ctrl.sv -----
// Controller state machine of the page allocator; issues commands to bfpa_dp.
// Depends on bfpa_pkg.
module bfpa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bfpa_pkg::stat_t stat_i,
  output bfpa_pkg::cmd_e  cmd_o
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = bfpa_pkg::CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLR: begin
        if (stat_i.sweep_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o = bfpa_pkg::CMD_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = bfpa_pkg::CMD_LOAD;
          if (stat_i.is_init) begin
            state_d = S_WRITE;
          end else if (stat_i.pre_err) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.sweep_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o = bfpa_pkg::CMD_RD;
        end
      end
      S_DRAIN: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o   = bfpa_pkg::CMD_EVAL;
        state_d = stat_i.do_write ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        if (stat_i.sweep_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o = bfpa_pkg::CMD_WR;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = bfpa_pkg::CMD_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/best_fit_page_allocator.sv -----
// Per item: init writes the whole map; alloc reads it all, then writes n pages (no fit:
// none); free reads its n pages, then writes them (refused after the read); incref/decref
// read and write their page; getref and refused count updates only read; errors found on
// entry go straight to the result. One item at a time: the next item is taken once its
// result is loaded; a waiting result stalls. Reset: asynchronous, active low; then a clearing
// pass zeroes the page memory before the first item. Depends on bfpa_pkg, bfpa_ctrl and bfpa_dp.
module best_fit_page_allocator #(
  parameter int MAP_PAGES   = bfpa_pkg::MAP_PAGES,
  parameter int COUNT_WIDTH = bfpa_pkg::COUNT_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfpa_pkg::FFP_W-1:0]     first_free_page_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bfpa_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [bfpa_pkg::INDEX_W-1:0]   page_index_i,
  input  logic [bfpa_pkg::NCOUNT_W-1:0]  page_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bfpa_pkg::STATUS_W-1:0]  status_o,
  output logic [bfpa_pkg::INDEX_W-1:0]   base_page_o,
  output logic [bfpa_pkg::OUTCNT_W-1:0]  count_value_o,
  output logic                           pages_freed_o
);

  // The register is taken in any cycle; the user must write it only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  bfpa_pkg::cmd_e  cmd;
  bfpa_pkg::stat_t stat;

  // The controller sequences each item: load and check the request, sweep the
  // memory (reading for alloc, free and the count operations), decide, then sweep
  // again to write if needed (init only writes; load errors skip to the result).
  // The result waits in the output register while the next item is already accepted.
  bfpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfpa_dp #(
    .MAP_PAGES   (MAP_PAGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .first_free_page_i (first_free_page_i),
    .opcode_i          (opcode_i),
    .page_index_i      (page_index_i),
    .page_count_i      (page_count_i),
    .status_o          (status_o),
    .base_page_o       (base_page_o),
    .count_value_o     (count_value_o),
    .pages_freed_o     (pages_freed_o)
  );

  // Accepting an item always takes the block out of idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted item did not leave idle");

  // Only a successful free hands pages back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pages_freed_o |-> status_o == bfpa_pkg::ST_OK)
    else $error("pages freed with error status");

  // A failed allocation reports no block and no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bfpa_pkg::ST_NOFIT |->
      base_page_o == '0 && count_value_o == '0 && !pages_freed_o)
    else $error("no-fit result carries data");

endmodule
